>>> hdl/pats_pkg.sv
// ----------------------------------------------------------------------------
// pats_pkg: shared types and constants for the priority aging scheduler
// Command codes, cell control bundle, scan carry and controller states.
// ----------------------------------------------------------------------------
package pats_pkg;

  localparam int TASK_SLOTS_DEFAULT = 16;

  localparam int KIND_W  = 2;
  localparam int SLOT_W  = 4;
  localparam int PRIO_W  = 32;
  localparam int SHIFT_W = 5;
  localparam int TIME_W  = 16;
  localparam int SLICE_W = 41;
  localparam int SCALE_W = 10;
  localparam int PROD_W  = PRIO_W + SCALE_W;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 10'd100;

  localparam logic [KIND_W-1:0] KIND_ADD      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK     = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DISPATCH = 2'd3;

  localparam logic [SLICE_W-1:0] SLICE_MAX = {1'b0, {(SLICE_W-1){1'b1}}};
  localparam logic [SLICE_W-1:0] SLICE_MIN = {1'b1, {(SLICE_W-1){1'b0}}};

  typedef enum logic [1:0] {
    CELL_IDLE,
    CELL_ADD,
    CELL_REMOVE,
    CELL_COMMIT
  } cell_op_t;

  // broadcast to every cell
  typedef struct packed {
    cell_op_t            op;
    logic                tick;       // scan is a tick (else a dispatch lookup)
    logic                expire;
    logic                run_valid;
    logic [TIME_W-1:0]   elapsed;
    logic [PRIO_W-1:0]   prio;
    logic [SHIFT_W-1:0]  shift;
  } cell_ctl_t;

  // best candidate handed from cell to cell
  typedef struct packed {
    logic              found;
    logic [PRIO_W-1:0] best;
  } carry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_COMMIT,
    ST_FINISH
  } pats_state_t;

endpackage

>>> hdl/pats_cmd_if.sv
// ----------------------------------------------------------------------------
// pats_cmd_if: command channel
// valid/ready handshake carrying one scheduler command per beat.
// ----------------------------------------------------------------------------
interface pats_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [pats_pkg::KIND_W-1:0]  kind;
  logic [pats_pkg::SLOT_W-1:0]  task_slot;
  logic [pats_pkg::PRIO_W-1:0]  initial_priority;
  logic signed [pats_pkg::SHIFT_W-1:0] aging_shift;
  logic [pats_pkg::TIME_W-1:0]  time_elapsed;

  modport source (
    output valid, kind, task_slot, initial_priority, aging_shift, time_elapsed,
    input  ready
  );
  modport sink (
    input  valid, kind, task_slot, initial_priority, aging_shift, time_elapsed,
    output ready
  );
endinterface

>>> hdl/pats_res_if.sv
// ----------------------------------------------------------------------------
// pats_res_if: result channel
// valid/ready handshake carrying one scheduler status beat per command.
// ----------------------------------------------------------------------------
interface pats_res_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 switch_request;
  logic                                 next_valid;
  logic [pats_pkg::SLOT_W-1:0]          next_slot;
  logic                                 current_valid;
  logic [pats_pkg::SLOT_W-1:0]          current_slot;
  logic signed [pats_pkg::SLICE_W-1:0]  current_slice;

  modport source (
    output valid, switch_request, next_valid, next_slot, current_valid,
           current_slot, current_slice,
    input  ready
  );
  modport sink (
    input  valid, switch_request, next_valid, next_slot, current_valid,
           current_slot, current_slice,
    output ready
  );
endinterface

>>> hdl/priority_aging_task_scheduler.sv
// ----------------------------------------------------------------------------
// priority_aging_task_scheduler: task slot table with priority aging
// Controller, running/chosen task registers and the chain of slot cells.
// ----------------------------------------------------------------------------
// One command is handled at a time. Add and remove go from the accepted beat
// straight to the finish state and the result register; a tick or a dispatch
// first passes through the sweep state, because the scan token walks the chain
// of slot cells one cell per cycle, and a dispatch that starts a task then
// passes through the commit state after its registered multiply.
// A new command is taken once the previous result has been loaded into the
// output register. slice_scale may only be written while no command is in
// flight.
module priority_aging_task_scheduler #(
  parameter int TASK_SLOTS = pats_pkg::TASK_SLOTS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [pats_pkg::SCALE_W-1:0]   cfg_wdata,
  pats_cmd_if.sink                       cmd,
  pats_res_if.source                     res
);

  localparam int SW = $clog2(TASK_SLOTS);

  pats_pkg::pats_state_t state, state_next;

  logic [pats_pkg::SCALE_W-1:0]  slice_scale;
  logic                          running_valid;
  logic [SW-1:0]                 running_slot;
  logic [pats_pkg::SLICE_W-1:0]  running_slice;
  logic                          chosen_valid;
  logic [SW-1:0]                 chosen_slot;
  logic                          sweep_tick;
  logic                          expire_q;
  logic [pats_pkg::TIME_W-1:0]   elapsed_q;
  logic                          launch;
  logic                          sw_q;
  logic [pats_pkg::PROD_W-1:0]   prod_q;

  logic                          accept;
  logic                          in_range;
  logic [SW-1:0]                 cmd_slot;
  logic                          hit_run;
  logic                          hit_chosen;
  logic                          load_out;
  logic                          sweep_done;
  logic                          dispatch_ok;
  pats_pkg::cell_op_t            cell_op;
  pats_pkg::cell_ctl_t           ctl;

  logic [pats_pkg::SLICE_W:0]    diff;
  logic [pats_pkg::SLICE_W-1:0]  slice_dec;
  logic [pats_pkg::SLICE_W-1:0]  slice_disp;

  logic                          token [TASK_SLOTS+1];
  pats_pkg::carry_t              carry [TASK_SLOTS+1];
  logic [SW-1:0]                 carry_slot [TASK_SLOTS+1];

  // ---------------- command decode ----------------
  assign accept     = cmd.valid && cmd.ready;
  assign in_range   = 32'(cmd.task_slot) < 32'(TASK_SLOTS);
  assign cmd_slot   = SW'(cmd.task_slot);
  assign hit_run    = running_valid && running_slot == cmd_slot;
  assign hit_chosen = chosen_valid && chosen_slot == cmd_slot;

  // slice minus elapsed, saturating at the most negative slice
  always_comb begin
    diff = {running_slice[pats_pkg::SLICE_W-1], running_slice} -
           (pats_pkg::SLICE_W+1)'(cmd.time_elapsed);
    if (diff[pats_pkg::SLICE_W:pats_pkg::SLICE_W-1] == 2'b10) begin
      slice_dec = pats_pkg::SLICE_MIN;
    end else begin
      slice_dec = diff[pats_pkg::SLICE_W-1:0];
    end
    if (prod_q[pats_pkg::PROD_W-1:pats_pkg::SLICE_W-1] != '0) begin
      slice_disp = pats_pkg::SLICE_MAX;
    end else begin
      slice_disp = prod_q[pats_pkg::SLICE_W-1:0];
    end
  end

  assign sweep_done  = token[TASK_SLOTS];
  assign dispatch_ok = chosen_valid && carry[TASK_SLOTS].found;

  // ---------------- state machine ----------------
  always_comb begin
    state_next = state;
    unique case (state)
      pats_pkg::ST_IDLE: begin
        if (accept) begin
          if (cmd.kind == pats_pkg::KIND_TICK || cmd.kind == pats_pkg::KIND_DISPATCH) begin
            state_next = pats_pkg::ST_SWEEP;
          end else begin
            state_next = pats_pkg::ST_FINISH;
          end
        end
      end
      pats_pkg::ST_SWEEP: begin
        if (sweep_done) begin
          if (!sweep_tick && dispatch_ok) begin
            state_next = pats_pkg::ST_COMMIT;
          end else begin
            state_next = pats_pkg::ST_FINISH;
          end
        end
      end
      pats_pkg::ST_COMMIT: state_next = pats_pkg::ST_FINISH;
      pats_pkg::ST_FINISH: begin
        if (!res.valid || res.ready) begin
          state_next = pats_pkg::ST_IDLE;
        end
      end
      default: state_next = pats_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.ready = 1'b0;
    cell_op   = pats_pkg::CELL_IDLE;
    load_out  = 1'b0;
    unique case (state)
      pats_pkg::ST_IDLE: begin
        cmd.ready = 1'b1;
        if (cmd.valid && in_range) begin
          if (cmd.kind == pats_pkg::KIND_ADD) begin
            cell_op = pats_pkg::CELL_ADD;
          end else if (cmd.kind == pats_pkg::KIND_REMOVE) begin
            cell_op = pats_pkg::CELL_REMOVE;
          end
        end
      end
      pats_pkg::ST_COMMIT: cell_op = pats_pkg::CELL_COMMIT;
      pats_pkg::ST_FINISH: load_out = !res.valid || res.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pats_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------- scheduler registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      slice_scale   <= pats_pkg::SCALE_RESET;
      running_valid <= 1'b0;
      running_slot  <= '0;
      running_slice <= '0;
      chosen_valid  <= 1'b0;
      chosen_slot   <= '0;
      sweep_tick    <= 1'b0;
      expire_q      <= 1'b0;
      launch        <= 1'b0;
      sw_q          <= 1'b0;
    end else begin
      launch <= 1'b0;
      if (cfg_we) begin
        slice_scale <= cfg_wdata;
      end

      if (accept) begin
        sw_q       <= 1'b0;
        sweep_tick <= cmd.kind == pats_pkg::KIND_TICK;
        elapsed_q  <= cmd.time_elapsed;
        unique case (cmd.kind)
          pats_pkg::KIND_ADD, pats_pkg::KIND_REMOVE: begin
            if (in_range) begin
              if (hit_run) begin
                running_valid <= 1'b0;
                running_slot  <= '0;
                running_slice <= '0;
              end
              if (hit_chosen) begin
                chosen_valid <= 1'b0;
                chosen_slot  <= '0;
              end
            end
          end
          pats_pkg::KIND_TICK: begin
            launch <= 1'b1;
            if (running_valid) begin
              running_slice <= slice_dec;
              expire_q      <= slice_dec[pats_pkg::SLICE_W-1];
            end else begin
              expire_q <= 1'b1;
            end
          end
          pats_pkg::KIND_DISPATCH: launch <= 1'b1;
          default: ;
        endcase
      end

      if (state == pats_pkg::ST_SWEEP && sweep_done) begin
        if (sweep_tick) begin
          chosen_valid <= carry[TASK_SLOTS].found;
          chosen_slot  <= carry[TASK_SLOTS].found ? carry_slot[TASK_SLOTS] : '0;
          sw_q         <= expire_q && carry[TASK_SLOTS].found;
        end
      end

      if (state == pats_pkg::ST_COMMIT) begin
        running_valid <= 1'b1;
        running_slot  <= chosen_slot;
        running_slice <= slice_disp;
        chosen_valid  <= 1'b0;
        chosen_slot   <= '0;
      end
    end
  end

  // priority times scale, registered before saturation
  always_ff @(posedge clk) begin
    prod_q <= pats_pkg::PROD_W'(carry[TASK_SLOTS].best) *
              pats_pkg::PROD_W'(slice_scale);
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (load_out) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res.switch_request <= sw_q;
      res.next_valid     <= chosen_valid;
      res.next_slot      <= chosen_valid ? pats_pkg::SLOT_W'(chosen_slot) : '0;
      res.current_valid  <= running_valid;
      res.current_slot   <= running_valid ? pats_pkg::SLOT_W'(running_slot) : '0;
      res.current_slice  <= running_valid ? running_slice : '0;
    end
  end

  // ---------------- cell chain ----------------
  always_comb begin
    ctl.op        = cell_op;
    ctl.tick      = sweep_tick;
    ctl.expire    = expire_q;
    ctl.run_valid = running_valid;
    ctl.elapsed   = elapsed_q;
    ctl.prio      = cmd.initial_priority;
    ctl.shift     = cmd.aging_shift;
  end

  assign token[0]      = launch;
  assign carry[0]      = '0;
  assign carry_slot[0] = '0;

  for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_cell
    pats_cell #(
      .IDX (i),
      .SW  (SW)
    ) u_cell (
      .clk            (clk),
      .rst            (rst),
      .ctl            (ctl),
      .ctl_slot       (cmd_slot),
      .run_slot       (running_slot),
      .sel_slot       (chosen_slot),
      .token_in       (token[i]),
      .carry_in       (carry[i]),
      .carry_slot_in  (carry_slot[i]),
      .token_out      (token[i+1]),
      .carry_out      (carry[i+1]),
      .carry_slot_out (carry_slot[i+1])
    );
  end

endmodule

>>> hdl/pats_cell.sv
// ----------------------------------------------------------------------------
// pats_cell: one task slot of the scheduler chain
// Holds the slot state, ages it when the scan token passes on a tick and hands
// the best candidate so far (on a dispatch lookup, the selected slot) on to the next cell.
// ----------------------------------------------------------------------------
module pats_cell #(
  parameter int IDX = 0,
  parameter int SW  = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  pats_pkg::cell_ctl_t ctl,
  input  logic [SW-1:0]       ctl_slot,
  input  logic [SW-1:0]       run_slot,
  input  logic [SW-1:0]       sel_slot,
  input  logic                token_in,
  input  pats_pkg::carry_t    carry_in,
  input  logic [SW-1:0]       carry_slot_in,
  output logic                token_out,
  output pats_pkg::carry_t    carry_out,
  output logic [SW-1:0]       carry_slot_out
);

  localparam logic [SW-1:0] MY_SLOT = SW'(IDX);
  localparam int INC_W = pats_pkg::PRIO_W - 1;

  logic                          valid;
  logic                          waiting;
  logic [pats_pkg::PRIO_W-1:0]   prio;
  logic [pats_pkg::SHIFT_W-1:0]  shift;

  logic                          valid_next;
  logic                          waiting_next;
  logic [pats_pkg::PRIO_W-1:0]   prio_next;
  logic [pats_pkg::SHIFT_W-1:0]  shift_next;
  pats_pkg::carry_t              carry_next;
  logic [SW-1:0]                 carry_slot_next;

  logic                          cand;
  logic [pats_pkg::PRIO_W-1:0]   base;
  logic [pats_pkg::SHIFT_W-1:0]  neg_shift;
  logic [INC_W-1:0]              inc;
  logic [pats_pkg::PRIO_W:0]     sum;
  logic [pats_pkg::PRIO_W-1:0]   aged;

  always_comb begin
    cand = valid && waiting;
    // an expired running task drops to zero priority
    base = (ctl.tick && ctl.expire && ctl.run_valid && run_slot == MY_SLOT) ?
           '0 : prio;
    neg_shift = pats_pkg::SHIFT_W'(~shift + 1'b1);
    if (shift[pats_pkg::SHIFT_W-1]) begin
      inc = INC_W'(ctl.elapsed >> neg_shift);
    end else begin
      inc = INC_W'(ctl.elapsed) << shift[pats_pkg::SHIFT_W-2:0];
    end
    sum  = {1'b0, base} + {2'b00, inc};
    aged = sum[pats_pkg::PRIO_W] ? '1 : sum[pats_pkg::PRIO_W-1:0];
  end

  always_comb begin
    valid_next      = valid;
    waiting_next    = waiting;
    prio_next       = prio;
    shift_next      = shift;
    carry_next      = carry_in;
    carry_slot_next = carry_slot_in;

    if (token_in) begin
      if (ctl.tick) begin
        prio_next = cand ? aged : base;
        if (cand && aged > carry_in.best) begin
          carry_next.found = 1'b1;
          carry_next.best  = aged;
          carry_slot_next  = MY_SLOT;
        end
      end else if (sel_slot == MY_SLOT) begin
        // dispatch lookup: report the selected slot's priority
        carry_next.found = cand;
        carry_next.best  = prio;
        carry_slot_next  = MY_SLOT;
      end
    end

    unique case (ctl.op)
      pats_pkg::CELL_ADD: begin
        if (ctl_slot == MY_SLOT) begin
          valid_next   = 1'b1;
          waiting_next = 1'b1;
          prio_next    = ctl.prio;
          shift_next   = ctl.shift;
        end
      end
      pats_pkg::CELL_REMOVE: begin
        if (ctl_slot == MY_SLOT) begin
          valid_next   = 1'b0;
          waiting_next = 1'b0;
          prio_next    = '0;
          shift_next   = '0;
        end
      end
      pats_pkg::CELL_COMMIT: begin
        if (ctl.run_valid && run_slot == MY_SLOT) begin
          waiting_next = 1'b1;
          prio_next    = '0;
        end
        if (sel_slot == MY_SLOT) begin
          waiting_next = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= 1'b0;
      waiting   <= 1'b0;
      prio      <= '0;
      shift     <= '0;
      token_out <= 1'b0;
    end else begin
      valid     <= valid_next;
      waiting   <= waiting_next;
      prio      <= prio_next;
      shift     <= shift_next;
      token_out <= token_in;
    end
  end

  always_ff @(posedge clk) begin
    carry_out      <= carry_next;
    carry_slot_out <= carry_slot_next;
  end

endmodule
